// File: sv/npst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npst_pkg
// Shared types and codes of the node pair slot table: request functions,
// response status codes and the layout of one stored table entry.
// ----------------------------------------------------------------------------
package npst_pkg;

   typedef logic [1:0]  func_type;
   typedef logic [1:0]  status_type;
   typedef logic [15:0] node_id_type;
   typedef logic [31:0] resets_type;
   typedef logic [3:0]  slot_type;
   typedef logic [4:0]  active_type;

   // request function codes
   localparam func_type FUNC_LOOKUP    = 2'd0;
   localparam func_type FUNC_RESET_ALL = 2'd1;
   localparam func_type FUNC_STATS     = 2'd2;

   // lookup status codes
   localparam status_type ST_FOUND   = 2'd0;
   localparam status_type ST_CREATED = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

   // one stored entry: the node pair and its reset count
   typedef struct packed {
      node_id_type initiator;
      node_id_type responder;
      resets_type  resets;
   } entry_type;

endpackage

// File: sv/npst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npst_if
// Valid/ready channels of the node pair slot table: the request channel
// and the response channel, each with a source and a sink view.
// ----------------------------------------------------------------------------
interface npst_req_if;
   import npst_pkg::*;

   logic        valid;
   logic        ready;
   func_type    func;
   node_id_type init_node;
   node_id_type resp_node;

   modport source (output valid, output func, output init_node,
                   output resp_node, input ready);
   modport sink   (input valid, input func, input init_node,
                   input resp_node, output ready);
endinterface

interface npst_rsp_if;
   import npst_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   slot_type   slot_index;
   resets_type slot_resets;
   active_type active_entries;

   modport source (output valid, output status, output slot_index,
                   output slot_resets, output active_entries, input ready);
   modport sink   (input valid, input status, input slot_index,
                   input slot_resets, input active_entries, output ready);
endinterface

// File: sv/npst_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npst_entry_mem
// Entry store: one write port and one read port, registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module npst_entry_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  npst_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output npst_pkg::entry_type rd_data
);
   import npst_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/node_pair_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_pair_slot_table
// Operation: one request at a time (ready only while idle). A lookup
// scans slots 0..count-1 in order and stops at the first match; on a miss
// it stores the pair at slot count, or reports full once MAX_PAIRS slots
// are used. A reset-all bumps the reset count of every valid slot;
// statistics go straight to the response. Each scanned slot takes two
// steps (read, then compare or update) through the entry memory.
// Reset: synchronous; empties the table at once (the fill count marks
// slots 0..count-1 valid), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module node_pair_slot_table #(
   parameter int MAX_PAIRS = 16
) (
   input  logic  clock,
   input  logic  reset,
   npst_req_if.sink   req_ch,
   npst_rsp_if.source rsp_ch
);
   import npst_pkg::*;

   localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAIRS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // sequencer state codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_CREATE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   func_type      func_ff, func_in;
   node_id_type   ini_ff, ini_in;
   node_id_type   rsp_id_ff, rsp_id_in;
   status_type    res_status_ff, res_status_in;
   logic [CW-1:0] res_slot_ff, res_slot_in;
   resets_type    res_resets_ff, res_resets_in;

   logic          out_valid_ff, out_valid_in;
   status_type    out_status_ff, out_status_in;
   slot_type      out_slot_ff, out_slot_in;
   resets_type    out_resets_ff, out_resets_in;
   active_type    out_active_ff, out_active_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data, rd_data;
   logic          req_take, out_free, hit, last_slot;
   logic [CW-1:0] ptr_next;

   npst_entry_mem #(
      .DEPTH (MAX_PAIRS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // handshake
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign hit       = (rd_data.initiator == ini_ff) && (rd_data.responder == rsp_id_ff);
   assign ptr_next  = ptr_ff + CNT_ONE;
   assign last_slot = (ptr_next == count_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      func_in       = func_ff;
      ini_in        = ini_ff;
      rsp_id_in     = rsp_id_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_resets_in = res_resets_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[AW-1:0];
      wr_data       = '{initiator: rd_data.initiator, responder: rd_data.responder,
                        resets: rd_data.resets + 32'd1};
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_resets_in = out_resets_ff;
      out_active_in = out_active_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in       = req_ch.func;
               ini_in        = req_ch.init_node;
               rsp_id_in     = req_ch.resp_node;
               ptr_in        = '0;
               res_status_in = ST_FOUND;
               res_slot_in   = '0;
               res_resets_in = '0;
               if (req_ch.func == FUNC_LOOKUP) begin
                  state_in = (count_ff == '0) ? S_CREATE : S_READ;
               end else if (req_ch.func == FUNC_RESET_ALL) begin
                  state_in = (count_ff == '0) ? S_DONE : S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            ptr_in = ptr_next;
            if (func_ff == FUNC_LOOKUP) begin
               if (hit) begin
                  res_status_in = ST_FOUND;
                  res_slot_in   = ptr_ff;
                  res_resets_in = rd_data.resets;
                  state_in      = S_DONE;
               end else begin
                  state_in = last_slot ? S_CREATE : S_READ;
               end
            end else begin
               // reset-all: bump this slot's count
               wr_en    = 1'b1;
               state_in = last_slot ? S_DONE : S_READ;
            end
         end
         S_CREATE: begin
            if (count_ff == CNT_MAX) begin
               res_status_in = ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[AW-1:0];
               wr_data       = '{initiator: ini_ff, responder: rsp_id_ff, resets: '0};
               count_in      = count_ff + CNT_ONE;
               res_status_in = ST_CREATED;
               res_slot_in   = count_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = slot_type'(res_slot_ff);
               out_resets_in = res_resets_ff;
               out_active_in = active_type'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      func_ff       <= func_in;
      ini_ff        <= ini_in;
      rsp_id_ff     <= rsp_id_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_resets_ff <= res_resets_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_resets_ff <= out_resets_in;
      out_active_ff <= out_active_in;
   end

   // response channel
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.slot_index     = out_slot_ff;
   assign rsp_ch.slot_resets    = out_resets_ff;
   assign rsp_ch.active_entries = out_active_ff;

endmodule
